### design/tksd_pkg.sv
// types and constants of the terminal key sequence decoder
// no dependencies; imported by the top level

package tksd_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_CSI    = 2'd2,
      MODE_SS3    = 2'd3
   } mode_type;

   localparam int UTF8_CNT_W = 3;
   localparam int CSI_NUM_W  = 17;

   // key codes
   localparam logic [4:0] K_CHAR  = 5'd0;
   localparam logic [4:0] K_UP    = 5'd1;
   localparam logic [4:0] K_DOWN  = 5'd2;
   localparam logic [4:0] K_RIGHT = 5'd3;
   localparam logic [4:0] K_LEFT  = 5'd4;
   localparam logic [4:0] K_HOME  = 5'd5;
   localparam logic [4:0] K_END   = 5'd6;
   localparam logic [4:0] K_PGUP  = 5'd7;
   localparam logic [4:0] K_PGDN  = 5'd8;
   localparam logic [4:0] K_INS   = 5'd9;
   localparam logic [4:0] K_DEL   = 5'd10;
   localparam logic [4:0] K_ENTER = 5'd11;
   localparam logic [4:0] K_BKSP  = 5'd12;
   localparam logic [4:0] K_TAB   = 5'd13;
   localparam logic [4:0] K_ESC   = 5'd14;
   localparam logic [4:0] K_F1    = 5'd15;

   // byte values
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CTL_Z = 8'h1A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_FIN_LO = 8'h40;
   localparam logic [7:0] CH_FIN_HI = 8'h7E;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CTRL_OFS = 8'h60;

   localparam logic [19:0] CSI_NUM_LIMIT = 20'd100000;

   // csi flag bits
   localparam int FLAG_SCANNING = 0;
   localparam int FLAG_SEEN     = 1;
   localparam int FLAG_OVERFLOW = 2;

   typedef struct packed {
      logic [4:0]  key_code;
      logic        ctrl_mod;
      logic [31:0] text_bytes;
      logic [2:0]  text_len;
      logic        last_of_run;
   } result_type;

   localparam result_type RESULT_NONE = '{5'd0, 1'b0, 32'd0, 3'd0, 1'b0};

   function automatic logic [UTF8_CNT_W-1:0] lead_length(input logic [7:0] c);
      logic [UTF8_CNT_W-1:0] len;
      if (c[7] == 1'b0)
         len = 3'd1;
      else if ((c & 8'hE0) == 8'hC0)
         len = 3'd2;
      else if ((c & 8'hF0) == 8'hE0)
         len = 3'd3;
      else if ((c & 8'hF8) == 8'hF0)
         len = 3'd4;
      else
         len = 3'd1;
      return len;
   endfunction

   function automatic result_type key_word(input logic [4:0] code);
      result_type r;
      r = RESULT_NONE;
      r.key_code = code;
      return r;
   endfunction

endpackage

### design/tksd_req_if.sv
// input channel: one raw terminal byte per word
// depends on nothing

interface tksd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

### design/tksd_rsp_if.sv
// result channel: one key event per word
// depends on nothing

interface tksd_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  key_code;
   logic        ctrl_mod;
   logic [31:0] text_bytes;
   logic [2:0]  text_len;
   logic        last_of_run;

   modport source (output valid, output key_code, output ctrl_mod, output text_bytes,
                   output text_len, output last_of_run, input ready);
   modport sink (input valid, input key_code, input ctrl_mod, input text_bytes,
                 input text_len, input last_of_run, output ready);
endinterface

### design/terminal_key_sequence_decoder.sv
// terminal key sequence decoder top level: parser state and a two-word result buffer
// depends on tksd_pkg, tksd_req_if and tksd_rsp_if

// Takes one terminal byte per word and turns it into key events. A byte is decoded in
// the cycle it is accepted and its events (zero, one or two) land in a two-word result
// buffer, so one byte per clock is taken while results drain one per clock. Input is
// ready when the buffer is empty or its last word leaves in the same cycle; a byte that
// gives two events (an escape that turns out to stand alone, followed by another key)
// holds off the next byte until one of them has left. Nothing needs clearing after reset.

module terminal_key_sequence_decoder
   import tksd_pkg::*;
#(
   parameter int UTF8_MAX     = 4,
   parameter int CSI_CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   tksd_req_if.sink    req,
   tksd_rsp_if.source  rsp
);

   localparam int CSI_CNT_W = $clog2(CSI_CAPACITY);

   mode_type                mode_ff, mode_in;
   logic                    cr_ff, cr_in;
   logic [UTF8_CNT_W-1:0]   exp_ff, exp_in;
   logic [UTF8_CNT_W-1:0]   ucnt_ff, ucnt_in;
   logic [7:0]              ubytes_ff [4];
   logic                    ub_we;
   logic [1:0]              ub_idx;
   logic [CSI_CNT_W-1:0]    csi_cnt_ff, csi_cnt_in;
   logic [CSI_NUM_W-1:0]    csi_num_ff, csi_num_in;
   logic [2:0]              csi_flags_ff, csi_flags_in;

   result_type              slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]              fill_ff, fill_in;

   logic       accept, pop;
   logic [7:0] c;
   result_type r0, r1;
   logic [1:0] nres;

   // normal-mode decode of the current byte
   logic       nb_valid;
   result_type nb_res;
   logic       nb_to_esc;
   logic       nb_cr;
   logic [UTF8_CNT_W-1:0] nb_exp, nb_cnt;
   logic       nb_we;
   logic [1:0] nb_idx;

   assign c      = req.byte_in;
   assign pop    = rsp.valid && rsp.ready;
   assign req.ready = (fill_ff == 2'd0) || ((fill_ff == 2'd1) && rsp.ready);
   assign accept = req.valid && req.ready;

   always_comb begin
      logic [UTF8_CNT_W-1:0] len;
      logic [7:0]            b;
      nb_valid  = 1'b0;
      nb_res    = RESULT_NONE;
      nb_to_esc = 1'b0;
      nb_cr     = cr_ff;
      nb_exp    = exp_ff;
      nb_cnt    = ucnt_ff;
      nb_we     = 1'b0;
      nb_idx    = ucnt_ff[1:0];
      len       = '0;
      b         = '0;
      if ((ucnt_ff != '0) && (ucnt_ff < exp_ff)) begin
         if (ucnt_ff < UTF8_CNT_W'(UTF8_MAX)) begin
            nb_we  = 1'b1;
            len    = ucnt_ff + 3'd1;
            nb_cnt = len;
            if (len >= exp_ff) begin
               nb_valid = 1'b1;
               nb_res.text_len = len;
               for (int i = 0; i < 4; i++) begin
                  b = (ucnt_ff[1:0] == 2'(i)) ? c : ubytes_ff[i];
                  nb_res.text_bytes[8*i +: 8] = (3'(i) < len) ? b : 8'h00;
               end
               nb_cnt = '0;
               nb_exp = '0;
            end
         end else begin
            // character longer than the store: drop it
            nb_cnt = '0;
            nb_exp = '0;
         end
      end else if (c == CH_ESC) begin
         nb_cr     = 1'b0;
         nb_to_esc = 1'b1;
      end else if (c == CH_CR) begin
         nb_cr    = 1'b1;
         nb_valid = 1'b1;
         nb_res   = key_word(K_ENTER);
      end else if (c == CH_LF) begin
         if (cr_ff) begin
            nb_cr = 1'b0;
         end else begin
            nb_valid = 1'b1;
            nb_res   = key_word(K_ENTER);
         end
      end else if ((c == CH_DEL) || (c == CH_BS)) begin
         nb_cr    = 1'b0;
         nb_valid = 1'b1;
         nb_res   = key_word(K_BKSP);
      end else if (c == CH_TAB) begin
         nb_cr    = 1'b0;
         nb_valid = 1'b1;
         nb_res   = key_word(K_TAB);
      end else if ((c != 8'h00) && (c <= CH_CTL_Z)) begin
         nb_cr    = 1'b0;
         nb_valid = 1'b1;
         nb_res.key_code   = K_CHAR;
         nb_res.ctrl_mod   = 1'b1;
         nb_res.text_bytes = {24'd0, c + CTRL_OFS};
         nb_res.text_len   = 3'd1;
      end else if (c >= CH_SPACE) begin
         nb_cr  = 1'b0;
         nb_we  = 1'b1;
         nb_idx = 2'd0;
         nb_exp = lead_length(c);
         nb_cnt = 3'd1;
         if (nb_exp <= 3'd1) begin
            nb_valid = 1'b1;
            nb_res.text_bytes = {24'd0, c};
            nb_res.text_len   = 3'd1;
            nb_cnt = '0;
            nb_exp = '0;
         end
      end
   end

   // next state and events of one byte
   always_comb begin
      logic              cf_hit;
      logic [4:0]        cf_key;
      logic [19:0]       v;
      logic [CSI_NUM_W-1:0] n;
      logic              fin;
      mode_in      = mode_ff;
      cr_in        = cr_ff;
      exp_in       = exp_ff;
      ucnt_in      = ucnt_ff;
      ub_we        = 1'b0;
      ub_idx       = nb_idx;
      csi_cnt_in   = csi_cnt_ff;
      csi_num_in   = csi_num_ff;
      csi_flags_in = csi_flags_ff;
      r0   = RESULT_NONE;
      r1   = RESULT_NONE;
      nres = 2'd0;
      v    = '0;
      n    = '0;
      fin  = (c >= CH_FIN_LO) && (c <= CH_FIN_HI);

      cf_hit = 1'b1;
      cf_key = K_UP;
      unique case (c)
         CH_A:    cf_key = K_UP;
         CH_B:    cf_key = K_DOWN;
         CH_C:    cf_key = K_RIGHT;
         CH_D:    cf_key = K_LEFT;
         CH_H:    cf_key = K_HOME;
         CH_F:    cf_key = K_END;
         default: cf_hit = 1'b0;
      endcase

      unique case (mode_ff)
         MODE_ESC, MODE_SS3: begin
            if ((mode_ff == MODE_ESC) && (c == CH_LBRK)) begin
               mode_in      = MODE_CSI;
               csi_cnt_in   = '0;
               csi_num_in   = '0;
               csi_flags_in = 3'b001;
            end else if ((mode_ff == MODE_ESC) && (c == CH_O)) begin
               mode_in = MODE_SS3;
            end else if ((mode_ff == MODE_SS3) && fin) begin
               mode_in = MODE_NORMAL;
               if (cf_hit) begin
                  r0   = key_word(cf_key);
                  nres = 2'd1;
               end else if ((c >= CH_P) && (c <= CH_S)) begin
                  r0   = key_word(K_F1 + 5'(c - CH_P));
                  nres = 2'd1;
               end
            end else begin
               // lone escape, then the byte again in normal mode
               r0      = key_word(K_ESC);
               r1      = nb_res;
               nres    = nb_valid ? 2'd2 : 2'd1;
               mode_in = nb_to_esc ? MODE_ESC : MODE_NORMAL;
               cr_in   = nb_cr;
               exp_in  = nb_exp;
               ucnt_in = nb_cnt;
               ub_we   = nb_we;
            end
         end
         MODE_CSI: begin
            if (fin) begin
               mode_in = MODE_NORMAL;
               if (cf_hit) begin
                  r0   = key_word(cf_key);
                  nres = 2'd1;
               end else if (c == CH_TILDE) begin
                  n    = csi_flags_ff[FLAG_OVERFLOW] ? '0 : csi_num_ff;
                  nres = 2'd1;
                  case (n) inside
                     17'd1, 17'd7: r0 = key_word(K_HOME);
                     17'd4, 17'd8: r0 = key_word(K_END);
                     17'd5:        r0 = key_word(K_PGUP);
                     17'd6:        r0 = key_word(K_PGDN);
                     17'd2:        r0 = key_word(K_INS);
                     17'd3:        r0 = key_word(K_DEL);
                     [17'd11:17'd15]: r0 = key_word(K_F1 + (n[4:0] - 5'd11));
                     [17'd17:17'd21]: r0 = key_word(K_F1 + (n[4:0] - 5'd12));
                     17'd23, 17'd24:  r0 = key_word(K_F1 + (n[4:0] - 5'd13));
                     default:      nres = 2'd0;
                  endcase
               end
            end else if (csi_cnt_ff < CSI_CNT_W'(CSI_CAPACITY - 1)) begin
               csi_cnt_in = csi_cnt_ff + 1'b1;
               if (csi_flags_ff[FLAG_SCANNING]) begin
                  if ((c >= CH_0) && (c <= CH_9)) begin
                     csi_flags_in[FLAG_SEEN] = 1'b1;
                     v = {csi_num_ff, 3'b000} + {2'b00, csi_num_ff, 1'b0}
                         + {16'd0, c[3:0]};
                     if (v > CSI_NUM_LIMIT) begin
                        csi_flags_in[FLAG_OVERFLOW] = 1'b1;
                        csi_flags_in[FLAG_SCANNING] = 1'b0;
                     end else begin
                        csi_num_in = v[CSI_NUM_W-1:0];
                     end
                  end else begin
                     csi_flags_in[FLAG_SCANNING] = 1'b0;
                  end
               end
            end
         end
         default: begin
            r0      = nb_res;
            nres    = nb_valid ? 2'd1 : 2'd0;
            mode_in = nb_to_esc ? MODE_ESC : MODE_NORMAL;
            cr_in   = nb_cr;
            exp_in  = nb_exp;
            ucnt_in = nb_cnt;
            ub_we   = nb_we;
         end
      endcase

      if (nres == 2'd1)
         r0.last_of_run = 1'b1;
      if (nres == 2'd2)
         r1.last_of_run = 1'b1;
   end

   // result buffer
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         fill_in  = fill_ff - 2'd1;
      end
      if (accept) begin
         slot0_in = r0;
         slot1_in = r1;
         fill_in  = nres;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_ff        <= 1'b0;
         exp_ff       <= '0;
         ucnt_ff      <= '0;
         csi_cnt_ff   <= '0;
         csi_num_ff   <= '0;
         csi_flags_ff <= 3'b001;
         fill_ff      <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (accept) begin
            cr_ff        <= cr_in;
            exp_ff       <= exp_in;
            ucnt_ff      <= ucnt_in;
            csi_cnt_ff   <= csi_cnt_in;
            csi_num_ff   <= csi_num_in;
            csi_flags_ff <= csi_flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (accept && ub_we)
         ubytes_ff[ub_idx] <= c;
   end

   assign rsp.valid       = (fill_ff != 2'd0);
   assign rsp.key_code    = slot0_ff.key_code;
   assign rsp.ctrl_mod    = slot0_ff.ctrl_mod;
   assign rsp.text_bytes  = slot0_ff.text_bytes;
   assign rsp.text_len    = slot0_ff.text_len;
   assign rsp.last_of_run = slot0_ff.last_of_run;

endmodule
